// ----- rtl/md4_pkg.sv -----
// Shared constants, types and functions of the MD4 hash engine.
package md4_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [31:0] K_G = 32'h5a827999;
  localparam logic [31:0] K_H = 32'h6ed9eba1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned ROUNDS = 48;
  localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);

  // Group of a round: 0 = F, 1 = G, 2 = H.
  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;

  // Write request into the message block buffer.
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [3:0]  be;
    logic [31:0] data;
  } buf_wr_t;

  // Message word read in a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] j;
    j = rnd[3:0];
    case (rnd[5:4])
      GRP_F:   msg_index = j;
      GRP_G:   msg_index = {j[1:0], j[3:2]};
      GRP_H:   msg_index = {j[0], j[1], j[2], j[3]};
      default: msg_index = j;
    endcase
  endfunction

endpackage

// ----- rtl/md4_msg_buf.sv -----
// Sixteen-word message block buffer with byte-lane writes and one read port.
module md4_msg_buf (
  input  logic              clk,
  input  md4_pkg::buf_wr_t  wr,
  input  logic [3:0]        rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] words [16];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int i = 0; i < 4; i++) begin
        if (wr.be[i]) begin
          words[wr.addr][i*8 +: 8] <= wr.data[i*8 +: 8];
        end
      end
    end
  end

  assign rd_data = words[rd_addr];

endmodule

// ----- rtl/md4_round.sv -----
// Shared MD4 round unit: boolean function, add chain and left rotate.
module md4_round (
  input  logic [5:0]  rnd,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] m,
  output logic [31:0] t
);

  logic [31:0] f;
  logic [31:0] k;
  logic [4:0]  s;
  logic [31:0] sum;
  logic [63:0] dbl;

  always_comb begin
    case (rnd[5:4])
      md4_pkg::GRP_F: begin
        f = d ^ (b & (c ^ d));
        k = 32'h0;
        case (rnd[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      md4_pkg::GRP_G: begin
        f = (b & c) | (d & (b | c));
        k = md4_pkg::K_G;
        case (rnd[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        f = b ^ c ^ d;
        k = md4_pkg::K_H;
        case (rnd[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
  end

  assign sum = a + f + m + k;
  assign dbl = {sum, sum} << s;
  assign t   = dbl[63:32];

endmodule

// ----- rtl/md4_hash_engine.sv -----
// Top level of the MD4 hash engine: byte intake, padding sequencer, rounds, digest output.
//
// Input channel s_*: one item per message position. s_tdata is the byte, s_tuser
// says whether the byte is present, s_tlast ends the message. s_tready is high only
// while the engine waits for input.
// Output channel m_*: four items per message, the chaining words 0..3 of the digest
// (m_tuser is the word index, m_tlast marks word 3).
// A byte that does not fill a block is just stored. The 64th byte of a block starts the
// 48 rounds and one fold, all through the single round unit. Ending a message writes the
// pad byte, clears up to 15 following words, writes the two length words and runs the
// rounds and fold; a tail of 56 or more bytes adds a rounds/fold pass and a 16-word clear.
// The four digest items then follow, one per cycle while m_tready is high.
// A stalled receiver holds the engine in its output phase: no input is taken until
// the last digest word is accepted, after which the chain and byte count restart.
// Reset (rst, synchronous) loads the initial chain and clears the byte count.
module md4_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [1:0]  m_tuser,   // [1:0] word_index
  output logic        m_tlast    // last_word
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ROUND = 7'b0000010,
    ST_FOLD  = 7'b0000100,
    ST_PAD   = 7'b0001000,
    ST_CLR   = 7'b0010000,
    ST_LEN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    CTX_LOAD  = 3'b001,
    CTX_PAD   = 3'b010,
    CTX_FINAL = 3'b100
  } ctx_t;

  state_t      state;
  ctx_t        ctx;
  logic        pend_last;
  logic [60:0] byte_count;
  logic [5:0]  rnd;
  logic [3:0]  wptr;
  logic [1:0]  oidx;
  logic [31:0] chain [4];
  logic [31:0] va, vb, vc, vd;

  md4_pkg::buf_wr_t wr;
  logic [31:0]      msg_word;
  logic [31:0]      t;
  logic [5:0]       pos;
  logic             in_acc;

  assign pos    = byte_count[5:0];
  assign in_acc = s_tvalid && s_tready;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = chain[oidx];
  assign m_tuser  = oidx;
  assign m_tlast  = (oidx == 2'd3);

  md4_msg_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (md4_pkg::msg_index(rnd)),
    .rd_data (msg_word)
  );

  md4_round u_round (
    .rnd (rnd),
    .a   (va),
    .b   (vb),
    .c   (vc),
    .d   (vd),
    .m   (msg_word),
    .t   (t)
  );

  always_comb begin
    wr = '0;
    case (state)
      ST_IDLE: begin
        wr.en   = in_acc && s_tuser;
        wr.addr = pos[5:2];
        wr.be   = 4'b0001 << pos[1:0];
        wr.data = {4{s_tdata}};
      end
      ST_PAD: begin
        wr.en   = 1'b1;
        wr.addr = pos[5:2];
        for (int i = 0; i < 4; i++) begin
          wr.be[i] = (2'(i) >= pos[1:0]);
          wr.data[i*8 +: 8] = (2'(i) == pos[1:0]) ? md4_pkg::PAD_BYTE : 8'h00;
        end
      end
      ST_CLR: begin
        wr.en   = 1'b1;
        wr.addr = wptr;
        wr.be   = 4'hf;
        wr.data = 32'h0;
      end
      ST_LEN: begin
        wr.en   = 1'b1;
        wr.addr = wptr;
        wr.be   = 4'hf;
        wr.data = (wptr == 4'd15) ? byte_count[60:29] : {byte_count[28:0], 3'b000};
      end
      default: wr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ctx        <= CTX_LOAD;
      pend_last  <= 1'b0;
      byte_count <= '0;
      rnd        <= '0;
      wptr       <= '0;
      oidx       <= '0;
      chain[0]   <= md4_pkg::INIT_A;
      chain[1]   <= md4_pkg::INIT_B;
      chain[2]   <= md4_pkg::INIT_C;
      chain[3]   <= md4_pkg::INIT_D;
      va         <= md4_pkg::INIT_A;
      vb         <= md4_pkg::INIT_B;
      vc         <= md4_pkg::INIT_C;
      vd         <= md4_pkg::INIT_D;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            pend_last <= s_tlast;
            rnd       <= '0;
            if (s_tuser) begin
              byte_count <= byte_count + 61'd1;
              if (pos == 6'd63) begin
                ctx   <= CTX_LOAD;
                state <= ST_ROUND;
              end else if (s_tlast) begin
                state <= ST_PAD;
              end
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_ROUND: begin
          va  <= vd;
          vd  <= vc;
          vc  <= vb;
          vb  <= t;
          rnd <= rnd + 6'd1;
          if (rnd == md4_pkg::LAST_ROUND) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          va       <= chain[0] + va;
          vb       <= chain[1] + vb;
          vc       <= chain[2] + vc;
          vd       <= chain[3] + vd;
          rnd      <= '0;
          case (ctx)
            CTX_LOAD: state <= pend_last ? ST_PAD : ST_IDLE;
            CTX_PAD: begin
              ctx   <= CTX_FINAL;
              wptr  <= '0;
              state <= ST_CLR;
            end
            default: begin
              oidx  <= '0;
              state <= ST_OUT;
            end
          endcase
        end
        ST_PAD: begin
          ctx  <= (pos[5:3] == 3'd7) ? CTX_PAD : CTX_FINAL;
          wptr <= pos[5:2] + 4'd1;
          rnd  <= '0;
          if (pos[5:2] == 4'd15) begin
            state <= ST_ROUND;
          end else begin
            state <= ST_CLR;
          end
        end
        ST_CLR: begin
          if (wptr == 4'd15) begin
            if (ctx == CTX_PAD) begin
              wptr  <= wptr + 4'd1;
              state <= ST_ROUND;
            end else begin
              wptr  <= 4'd14;
              state <= ST_LEN;
            end
          end else begin
            wptr <= wptr + 4'd1;
          end
        end
        ST_LEN: begin
          wptr <= 4'd15;
          if (wptr == 4'd15) begin
            state <= ST_ROUND;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            oidx <= oidx + 2'd1;
            if (oidx == 2'd3) begin
              chain[0]   <= md4_pkg::INIT_A;
              chain[1]   <= md4_pkg::INIT_B;
              chain[2]   <= md4_pkg::INIT_C;
              chain[3]   <= md4_pkg::INIT_D;
              va         <= md4_pkg::INIT_A;
              vb         <= md4_pkg::INIT_B;
              vc         <= md4_pkg::INIT_C;
              vd         <= md4_pkg::INIT_D;
              byte_count <= '0;
              pend_last  <= 1'b0;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
